[rtl/dcd_pkg.sv]
// Package for the directed cycle detector: sizes, state encoding, the stack
// entry layout and the command/status bundles between controller and datapath.
// No dependencies.
package dcd_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int VERT_W       = 8;
  localparam int CFG_W        = 7;

  typedef logic [VIDX_W-1:0]       vidx_t;
  typedef logic [VCNT_W-1:0]       vcnt_t;
  typedef logic [MAX_VERTICES-1:0] vmap_t;

  typedef struct packed {
    vidx_t vertex;
    vcnt_t next;
  } stk_entry_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PICK,
    S_SCAN,
    S_RESTORE,
    S_DONE
  } dcd_state_t;

  typedef struct packed {
    logic load;
    logic search_init;
    logic next_start;
    logic take_start;
    logic advance;
    logic push;
    logic pop;
    logic restore;
    logic mark_found;
    logic emit;
  } dcd_cmd_t;

  typedef struct packed {
    logic start_end;
    logic start_visited;
    logic v_end;
    logic adj_bit;
    logic v_visited;
    logic v_on_path;
    logic depth_one;
    logic out_free;
  } dcd_sts_t;

endpackage

[rtl/dcd_ctrl.sv]
// Controller state machine of the directed cycle detector.
// Depends on dcd_pkg for the state type and the command/status bundles.
module dcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_edge,
  output logic              in_stall,
  input  dcd_pkg::dcd_sts_t sts,
  output dcd_pkg::dcd_cmd_t cmd
);
  import dcd_pkg::*;

  dcd_state_t state_r;
  dcd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_edge) begin
            cmd.search_init = 1'b1;
            state_nxt       = S_PICK;
          end
        end
      end
      S_PICK: begin
        priority if (sts.start_end) begin
          state_nxt = S_DONE;
        end else if (sts.start_visited) begin
          cmd.next_start = 1'b1;
        end else begin
          cmd.take_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // Edges into a vertex on the current path close a cycle; edges into
        // finished vertices are skipped; a fresh vertex is descended into.
        priority if (sts.v_end) begin
          cmd.pop = 1'b1;
          if (sts.depth_one) begin
            cmd.next_start = 1'b1;
            state_nxt      = S_PICK;
          end else begin
            state_nxt = S_RESTORE;
          end
        end else if (!sts.adj_bit) begin
          cmd.advance = 1'b1;
        end else if (sts.v_on_path) begin
          cmd.mark_found = 1'b1;
          state_nxt      = S_DONE;
        end else if (sts.v_visited) begin
          cmd.advance = 1'b1;
        end else begin
          cmd.push = 1'b1;
        end
      end
      S_RESTORE: begin
        cmd.restore = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

[rtl/dcd_datapath.sv]
// Datapath of the directed cycle detector: adjacency memory with row valid
// bits, walk stack memory, visited and path maps, walk registers, output register.
// Depends on dcd_pkg; driven by commands from dcd_ctrl.
module dcd_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [dcd_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic [dcd_pkg::VERT_W-1:0] in_src_vertex,
  input  logic [dcd_pkg::VERT_W-1:0] in_dst_vertex,
  input  logic                       in_edge_present,
  input  dcd_pkg::dcd_cmd_t          cmd,
  output dcd_pkg::dcd_sts_t          sts,
  output logic                       out_valid,
  output logic                       out_cycle_found,
  input  logic                       out_stall
);
  import dcd_pkg::*;

  vmap_t      adj_mem [MAX_VERTICES];
  stk_entry_t stk_mem [MAX_VERTICES];

  vmap_t              row_vld_r;
  vmap_t              row_q_r;
  logic               row_q_vld_r;
  stk_entry_t         stk_q_r;
  logic [CFG_W-1:0]   vertex_count_r;
  vcnt_t              start_r;
  vidx_t              cur_u_r;
  vcnt_t              cur_v_r;
  vcnt_t              depth_r;
  vmap_t              visited_r;
  vmap_t              on_path_r;
  logic               found_r;
  logic               out_valid_r;
  logic               out_cycle_found_r;

  vcnt_t              n_act;
  logic [VERT_W-1:0]  n_ext;
  logic               edge_keep;
  vidx_t              src_idx;
  vidx_t              dst_idx;
  vidx_t              start_idx;
  vidx_t              v_idx;
  logic               adj_rd;
  vidx_t              adj_ra;
  stk_entry_t         push_entry;

  // Counts above the vertex capacity saturate.
  assign n_act = (vertex_count_r > CFG_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                         : VCNT_W'(vertex_count_r);
  assign n_ext = VERT_W'(n_act);

  assign edge_keep = in_edge_present
                     && (in_src_vertex != '0) && (in_src_vertex <= n_ext)
                     && (in_dst_vertex != '0) && (in_dst_vertex <= n_ext)
                     && (in_src_vertex != in_dst_vertex);

  assign src_idx   = VIDX_W'(in_src_vertex - VERT_W'(1));
  assign dst_idx   = VIDX_W'(in_dst_vertex - VERT_W'(1));
  assign start_idx = start_r[VIDX_W-1:0];
  assign v_idx     = cur_v_r[VIDX_W-1:0];

  assign adj_rd = cmd.take_start || cmd.push || cmd.restore;
  always_comb begin
    priority if (cmd.take_start) begin
      adj_ra = start_idx;
    end else if (cmd.push) begin
      adj_ra = v_idx;
    end else begin
      adj_ra = stk_q_r.vertex;
    end
  end

  assign push_entry.vertex = cur_u_r;
  assign push_entry.next   = cur_v_r + VCNT_W'(1);

  // An invalid row is written whole, so stale bits from an earlier graph vanish.
  always_ff @(posedge clk) begin
    if (cmd.load && edge_keep) begin
      if (row_vld_r[src_idx]) begin
        adj_mem[src_idx][dst_idx] <= 1'b1;
      end else begin
        adj_mem[src_idx] <= vmap_t'(1) << dst_idx;
      end
    end
    if (adj_rd) begin
      row_q_r     <= adj_mem[adj_ra];
      row_q_vld_r <= row_vld_r[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[VIDX_W'(depth_r - VCNT_W'(1))] <= push_entry;
    end
    if (cmd.pop) begin
      stk_q_r <= stk_mem[VIDX_W'(depth_r - VCNT_W'(2))];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cycle_found_r <= found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r      <= '0;
      vertex_count_r <= CFG_W'(MAX_VERTICES);
      start_r        <= '0;
      cur_u_r        <= '0;
      cur_v_r        <= '0;
      depth_r        <= '0;
      visited_r      <= '0;
      on_path_r      <= '0;
      found_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count_r <= cfg_wr_data;
      end
      if (cmd.load && edge_keep) begin
        row_vld_r[src_idx] <= 1'b1;
      end
      if (cmd.search_init) begin
        start_r <= '0;
        found_r <= 1'b0;
      end
      if (cmd.next_start) begin
        start_r <= start_r + VCNT_W'(1);
      end
      if (cmd.take_start) begin
        cur_u_r              <= start_idx;
        cur_v_r              <= '0;
        depth_r              <= VCNT_W'(1);
        visited_r[start_idx] <= 1'b1;
        on_path_r[start_idx] <= 1'b1;
      end
      if (cmd.advance) begin
        cur_v_r <= cur_v_r + VCNT_W'(1);
      end
      if (cmd.push) begin
        cur_u_r          <= v_idx;
        cur_v_r          <= '0;
        depth_r          <= depth_r + VCNT_W'(1);
        visited_r[v_idx] <= 1'b1;
        on_path_r[v_idx] <= 1'b1;
      end
      if (cmd.pop) begin
        on_path_r[cur_u_r] <= 1'b0;
        depth_r            <= depth_r - VCNT_W'(1);
      end
      if (cmd.restore) begin
        cur_u_r <= stk_q_r.vertex;
        cur_v_r <= stk_q_r.next;
      end
      if (cmd.mark_found) begin
        found_r <= 1'b1;
      end
      if (cmd.emit) begin
        row_vld_r <= '0;
        visited_r <= '0;
        on_path_r <= '0;
        depth_r   <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.start_end     = (start_r == n_act);
  assign sts.start_visited = visited_r[start_idx];
  assign sts.v_end         = (cur_v_r == n_act);
  assign sts.adj_bit       = row_q_vld_r && row_q_r[v_idx];
  assign sts.v_visited     = visited_r[v_idx];
  assign sts.v_on_path     = on_path_r[v_idx];
  assign sts.depth_one     = (depth_r == VCNT_W'(1));
  assign sts.out_free      = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_cycle_found = out_cycle_found_r;

endmodule

[rtl/directed_cycle_detector.sv]
// Top level of the directed cycle detector: controller plus datapath.
// Depends on dcd_pkg, dcd_ctrl and dcd_datapath.
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  src_vertex, dst_vertex, edge_present, last_edge
//  out_     output     out_valid/out_stall  cycle_found
//  cfg_     input      cfg_wr_en            cfg_wr_data (vertex count)
//
// Edges load at one transfer per cycle while the input is not stalled. The item marked
// last starts a depth-first search: it picks start vertices in turn, scans each row
// one adjacency bit at a time, and takes an extra restore step on each return to a
// parent (stack memory read); the bit-serial row scan sets the search time.
// Reset is synchronous and active low; the graph stores are cleared in the cycle the
// result is registered (row valid bits, no sweep). The input stalls from the last
// item until the result is registered; edges of the next graph are taken while that
// result still waits on a stalled output.
module directed_cycle_detector (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [dcd_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dcd_pkg::VERT_W-1:0] in_src_vertex,
  input  logic [dcd_pkg::VERT_W-1:0] in_dst_vertex,
  input  logic                       in_edge_present,
  input  logic                       in_last_edge,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_cycle_found
);
  import dcd_pkg::*;

  dcd_cmd_t cmd;
  dcd_sts_t sts;

  // The controller sequences loading, the walk and the result transfer.
  dcd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_edge (in_last_edge),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // The datapath holds the graph, the walk stack and the output register.
  dcd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_src_vertex   (in_src_vertex),
    .in_dst_vertex   (in_dst_vertex),
    .in_edge_present (in_edge_present),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_cycle_found (out_cycle_found),
    .out_stall       (out_stall)
  );

  // Accepting the last item must start the search, which stalls the input.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_edge) |=> in_stall)
    else $error("input not stalled after the last item");

  // Registering a result presents it and reopens the input.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_valid && !in_stall))
    else $error("result not presented after registering");

  // The walk takes at most one step per cycle.
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.pop || cmd.advance) |-> $onehot({cmd.push, cmd.pop, cmd.advance}))
    else $error("conflicting walk steps");

endmodule

[tb/tb_directed_cycle_detector.sv]
// Self-checking testbench for directed_cycle_detector: drives edge lists, predicts the
// cycle verdict of every graph with its own depth-first search and checks each result.
// Depends on dcd_pkg and the directed_cycle_detector RTL.
`timescale 1ns / 1ps

module tb_directed_cycle_detector;
  import dcd_pkg::*;

  // Time allowed for the search of a full-size graph.
  localparam int SEARCH_CYCLES = MAX_VERTICES * (MAX_VERTICES + 3) + 2;
  // Cycles allowed after the last transfer before a register write. Loading an edge
  // is a registered write to the adjacency memory, so a short pause is plenty.
  localparam int LOAD_SETTLE   = 16;
  // The watchdog fires after this many cycles in which no transfer happens on
  // either channel. It covers a full search plus a long output stall several times.
  localparam int IDLE_LIMIT    = 40000;
  localparam int ITEM_TARGET   = 1700;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [VERT_W-1:0] src;
    logic [VERT_W-1:0] dst;
    logic              present;
    logic              last;
  } edge_xfer_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              cfg_wr_en       = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data     = '0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [VERT_W-1:0] in_src_vertex   = '0;
  logic [VERT_W-1:0] in_dst_vertex   = '0;
  logic              in_edge_present = 1'b0;
  logic              in_last_edge    = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic              out_cycle_found;

  // Predictor state: the adjacency matrix (row = tail - 1, bit = head - 1) and the
  // vertex count register as the block holds it.
  vmap_t             adj_rows [MAX_VERTICES];
  logic [CFG_W-1:0]  vertex_limit = 7'd64;

  edge_xfer_t        pending_edges [$];
  bit                cycle_verdicts [$];
  int                items_queued = 0;
  int                error_count  = 0;

  // Driver bookkeeping. driving mirrors the valid that the driver has decided on,
  // written in the same process as the queue pops, so the stimulus process never
  // sees an item that has left the queue but is not yet on the port.
  bit                driving    = 1'b0;
  int                burst_left = 0;
  int                gap_left   = 0;

  stall_mode_t       stall_mode = STALL_NONE;
  int                stall_left = 0;
  int                stall_tick = 0;
  int                idle_cycles = 0;

  directed_cycle_detector dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_src_vertex   (in_src_vertex),
    .in_dst_vertex   (in_dst_vertex),
    .in_edge_present (in_edge_present),
    .in_last_edge    (in_last_edge),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cycle_found (out_cycle_found)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      adj_rows[i] = '0;
    end
  end

  // A programmed count above the array size behaves as the full size.
  function automatic int active_vertices(input int count);
    return (count > MAX_VERTICES) ? MAX_VERTICES : count;
  endfunction

  // Iterative depth-first search over vertices 0..n-1 with an explicit path stack.
  // A cycle is declared on any edge into a vertex that is still on the current path;
  // edges into vertices finished earlier are cross edges and are passed over.
  function automatic bit graph_has_cycle(input int n);
    vmap_t seen;
    vmap_t on_path;
    int    walk_vertex [MAX_VERTICES];
    int    walk_next [MAX_VERTICES];
    int    depth;
    int    root;
    int    u;
    int    v;
    bit    found;
    bit    descended;
    seen    = '0;
    on_path = '0;
    found   = 1'b0;
    for (root = 0; root < n && !found; root++) begin
      if (!seen[root]) begin
        walk_vertex[0] = root;
        walk_next[0]   = 0;
        depth          = 1;
        seen[root]     = 1'b1;
        on_path[root]  = 1'b1;
        while (depth > 0 && !found) begin
          u         = walk_vertex[depth-1];
          v         = walk_next[depth-1];
          descended = 1'b0;
          while (v < n && !found && !descended) begin
            if (adj_rows[u][v]) begin
              if (on_path[v]) begin
                found = 1'b1;
              end else if (!seen[v]) begin
                // Remember where to resume in this row, then go one level deeper.
                walk_next[depth-1] = v + 1;
                walk_vertex[depth] = v;
                walk_next[depth]   = 0;
                depth++;
                seen[v]    = 1'b1;
                on_path[v] = 1'b1;
                descended  = 1'b1;
              end
            end
            v++;
          end
          if (!descended && !found) begin
            on_path[u] = 1'b0;
            depth--;
          end
        end
      end
    end
    return found;
  endfunction

  // Applies one accepted transfer to the predicted graph. The closing transfer
  // yields a verdict and leaves an empty graph behind.
  function automatic void absorb_transfer(input logic [VERT_W-1:0] src,
                                          input logic [VERT_W-1:0] dst,
                                          input logic present, input logic last);
    int n;
    n = active_vertices(vertex_limit);
    if (present && src >= 1 && src <= n && dst >= 1 && dst <= n && src != dst) begin
      adj_rows[src-1][dst-1] = 1'b1;
    end
    if (last) begin
      cycle_verdicts.insert(cycle_verdicts.size(), graph_has_cycle(n));
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj_rows[i] = '0;
      end
    end
  endfunction

  // Queues one transfer and counts it toward the amount of stimulus.
  task automatic push_edge(input int src, input int dst, input bit present, input bit last);
    edge_xfer_t item;
    item.src     = src[VERT_W-1:0];
    item.dst     = dst[VERT_W-1:0];
    item.present = present;
    item.last    = last;
    pending_edges.insert(pending_edges.size(), item);
    items_queued++;
  endtask

  // Waits until every queued transfer has gone in and every verdict has come out,
  // then lets the block settle so that a register write lands while it is idle.
  task automatic wait_quiet();
    while (pending_edges.size() != 0 || driving || cycle_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int count);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    vertex_limit  = count[CFG_W-1:0];
  endtask

  // Mostly small graphs keep the bit-serial search short; a few phases use the
  // full size, including programmed values that saturate, and zero or one vertex.
  function automatic int pick_vertex_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(2, 10);
    if (r < 84) return $urandom_range(11, 24);
    if (r < 89) return $urandom_range(0, 1);
    if (r < 95) return $urandom_range(25, 63);
    return $urandom_range(64, 127);
  endfunction

  // Queues the edges of one random graph, without the closing transfer. Most graphs
  // are well formed (acyclic orderings with an occasional back edge, or long chains
  // that may close on themselves); the rest is random edges. Dropped transfers are
  // sprinkled in: empty items, out-of-range endpoints and self-loops.
  task automatic queue_random_graph(input int count);
    int n;
    int order [MAX_VERTICES];
    int kind;
    int edges;
    int i;
    int j;
    int tmp;
    int k;
    int bad;
    n = active_vertices(count);
    for (i = 0; i < n; i++) begin
      order[i] = i + 1;
    end
    for (i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    kind = (n < 2) ? 9 : $urandom_range(0, 9);
    if (kind <= 4) begin
      edges = $urandom_range(0, 2 * n + 2);
    end else if (kind <= 6) begin
      edges = $urandom_range(0, n + 3);
    end else if (kind <= 8) begin
      edges = n - 1;
    end else begin
      edges = $urandom_range(0, 8);
    end
    for (k = 0; k < edges; k++) begin
      if (kind <= 4) begin
        i = $urandom_range(0, n - 2);
        j = $urandom_range(i + 1, n - 1);
        push_edge(order[i], order[j], 1'b1, 1'b0);
      end else if (kind <= 6) begin
        push_edge($urandom_range(1, n), $urandom_range(1, n), 1'b1, 1'b0);
      end else if (kind <= 8) begin
        push_edge(order[k], order[k+1], 1'b1, 1'b0);
      end else begin
        push_edge($urandom_range(0, 255), $urandom_range(0, 255), 1'b1, 1'b0);
      end
      if ($urandom_range(0, 7) == 0) begin
        bad = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(n + 1, 255);
        case ($urandom_range(0, 3))
          0: push_edge($urandom_range(0, 255), $urandom_range(0, 255), 1'b0, 1'b0);
          1: push_edge(bad, $urandom_range(0, 255), 1'b1, 1'b0);
          2: push_edge($urandom_range(0, 255), bad, 1'b1, 1'b0);
          default: begin
            tmp = (n == 0) ? $urandom_range(0, 255) : $urandom_range(1, n);
            push_edge(tmp, tmp, 1'b1, 1'b0);
          end
        endcase
      end
    end
    // Occasionally close the graph on itself: a back edge in an acyclic ordering,
    // which is a cycle only if the forward path happens to exist, or a chain that
    // loops back onto one of its own vertices, which always is.
    if (n >= 2 && kind <= 4 && $urandom_range(0, 1) == 0) begin
      i = $urandom_range(0, n - 2);
      j = $urandom_range(i + 1, n - 1);
      push_edge(order[j], order[i], 1'b1, 1'b0);
    end
    if (n >= 2 && (kind == 7 || kind == 8) && $urandom_range(0, 1) == 0) begin
      push_edge(order[n-1], order[$urandom_range(0, n - 2)], 1'b1, 1'b0);
    end
  endtask

  // Sender: takes items from the queue in bursts of random length, separated by
  // random gaps, and feeds every accepted transfer to the predictor.
  always @(posedge clk) begin : drive_edges
    edge_xfer_t item;
    bit         next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      driving   = 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        absorb_transfer(in_src_vertex, in_dst_vertex, in_edge_present, in_last_edge);
        next_valid = 1'b0;
      end
      // A stalled item keeps both its valid and its payload.
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_edges.size() != 0) begin
          item             = pending_edges.pop_front();
          in_src_vertex   <= item.src;
          in_dst_vertex   <= item.dst;
          in_edge_present <= item.present;
          in_last_edge    <= item.last;
          next_valid       = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // A third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid <= next_valid;
      driving   = next_valid;
    end
  end

  // Receiver: stalls on a pattern that is redrawn at random after a random hold, from
  // never stalling through random stalls of either density to a fixed rhythm.
  always @(posedge clk) begin : pace_results
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      stall_tick++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_tick % 7) < 3);
      endcase
    end
  end

  // Every result transfer is checked against the oldest predicted verdict.
  always @(posedge clk) begin : check_results
    bit want;
    if (rst_n && out_valid && !out_stall) begin
      if (cycle_verdicts.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none, actual cycle_found=%0b",
                   $time, out_cycle_found);
        end
      end else begin
        want = cycle_verdicts.pop_front();
        if (out_cycle_found !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: cycle_found mismatch, expected %0b, actual %0b",
                     $time, want, out_cycle_found);
          end
        end
      end
    end
  end

  // Ends the run if neither channel has moved a transfer for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_directed_cycle_detector: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int count;
    int graphs;
    int n;
    int pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset count of 64 vertices.
    // An empty graph: only the closing marker.
    push_edge(0, 0, 1'b0, 1'b1);
    // The smallest cycle, two vertices pointing at each other.
    push_edge(1, 2, 1'b1, 1'b0);
    push_edge(2, 1, 1'b1, 1'b1);
    // A self-loop is dropped, so no cycle.
    push_edge(3, 3, 1'b1, 1'b1);
    // Range extremes: vertex 64 is kept, 0, 65 and 255 are dropped.
    push_edge(64, 1, 1'b1, 1'b0);
    push_edge(0, 5, 1'b1, 1'b0);
    push_edge(255, 255, 1'b1, 1'b0);
    push_edge(65, 1, 1'b1, 1'b0);
    push_edge(1, 64, 1'b1, 1'b1);
    // A duplicate edge, and an empty item whose payload would close a cycle.
    push_edge(1, 2, 1'b1, 1'b0);
    push_edge(1, 2, 1'b1, 1'b0);
    push_edge(2, 3, 1'b1, 1'b0);
    push_edge(3, 1, 1'b0, 1'b0);
    push_edge(0, 0, 1'b0, 1'b1);
    // A diamond: the second path into vertex 4 is a cross edge, not a cycle.
    push_edge(1, 2, 1'b1, 1'b0);
    push_edge(1, 3, 1'b1, 1'b0);
    push_edge(2, 4, 1'b1, 1'b0);
    push_edge(3, 4, 1'b1, 1'b1);
    // No vertex in use: every edge is dropped.
    set_vertex_count(0);
    push_edge(1, 2, 1'b1, 1'b0);
    push_edge(2, 1, 1'b1, 1'b1);
    // A single vertex cannot hold a cycle.
    set_vertex_count(1);
    push_edge(1, 2, 1'b1, 1'b0);
    push_edge(2, 1, 1'b1, 1'b1);
    // The largest programmable count saturates to the full size.
    set_vertex_count(127);
    push_edge(64, 63, 1'b1, 1'b0);
    push_edge(63, 64, 1'b1, 1'b1);
    // The count shrinks between loading and search: the stored cycle on vertices
    // 9 and 10 lies above the new count and is ignored.
    set_vertex_count(10);
    push_edge(9, 10, 1'b1, 1'b0);
    push_edge(10, 9, 1'b1, 1'b0);
    set_vertex_count(8);
    push_edge(1, 2, 1'b1, 1'b1);

    // Random part: phases of a few graphs that mostly share one vertex count. Graphs
    // of a phase follow each other without a pause unless the count changes, so the next
    // graph loads while the previous verdict may still wait on a stalled output.
    while (items_queued < ITEM_TARGET) begin
      count = pick_vertex_count();
      set_vertex_count(count);
      graphs = $urandom_range(1, 6);
      for (int g = 0; g < graphs; g++) begin
        queue_random_graph(count);
        if ($urandom_range(0, 9) == 0) begin
          // Change the count after the edges are in but before the search.
          count = pick_vertex_count();
          set_vertex_count(count);
        end
        n    = active_vertices(count);
        pick = $urandom_range(0, 3);
        if (pick <= 1) begin
          push_edge($urandom_range(0, 255), $urandom_range(0, 255), 1'b0, 1'b1);
        end else if (pick == 2 && n >= 2) begin
          push_edge($urandom_range(1, n), $urandom_range(1, n), 1'b1, 1'b1);
        end else begin
          push_edge($urandom_range(0, 255), $urandom_range(0, 255), 1'b1, 1'b1);
        end
      end
    end

    // Drain, then leave room for a stray result from a late search.
    wait_quiet();
    repeat (SEARCH_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_directed_cycle_detector: PASS");
    end else begin
      $display("tb_directed_cycle_detector: FAIL");
    end
    $finish;
  end

endmodule
